### rtl/dpu_pkg.sv
package dpu_pkg;

   // frame geometry
   localparam int FRAME_WIDTH  = 640;
   localparam int FRAME_HEIGHT = 480;
   localparam int COL_BITS     = 10;
   localparam int ROW_BITS     = 9;
   localparam logic [COL_BITS-1:0] COL_LAST = COL_BITS'(FRAME_WIDTH - 1);
   localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(FRAME_HEIGHT - 1);

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEPTH_SLOPE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEPTH_OFFSET  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERSE_FOCAL = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_COLUMN = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_ROW    = 3'd4;

   // configuration reset values
   localparam logic [23:0] SLOPE_RESET  = 24'd3297570;
   localparam logic [31:0] OFFSET_RESET = 32'd3576579809;
   localparam logic [23:0] FOCAL_RESET  = 24'd33554;
   localparam logic [9:0]  CCOL_RESET   = 10'd320;
   localparam logic [9:0]  CROW_RESET   = 10'd240;

   // divider: two quotient bits per iteration, 26 quotient bits
   localparam int DIV_STEPS     = 13;
   localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);
   localparam int QUOT_BITS     = 2 * DIV_STEPS;
   localparam logic [23:0] Z_MAX = 24'hFF_FFFF;

   typedef struct packed {
      logic [23:0] depth_slope;
      logic [31:0] depth_offset;
      logic [23:0] inverse_focal;
      logic [9:0]  center_column;
      logic [9:0]  center_row;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEN_MUL,
      ST_DEN_SUB,
      ST_DIV_INIT,
      ST_DIV,
      ST_PROD,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic load;
      logic den_mul;
      logic den_sub;
      logic div_init;
      logic div_step;
      logic prod_mul;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } stat_type;

   // join partial products, round half away from zero, saturate, apply sign
   function automatic logic signed [24:0] lateral_finish(input logic [45:0] lo,
                                                         input logic [45:0] hi,
                                                         input logic        neg);
      logic [57:0] prod;
      logic [33:0] mag;
      logic [24:0] sat_mag;
      prod = {12'd0, lo} + {hi, 12'd0} + 58'(1 << 23);
      mag  = prod[57:24];
      if (neg) begin
         sat_mag = (mag > 34'h100_0000) ? 25'h100_0000 : mag[24:0];
         return $signed(~sat_mag + 25'd1);
      end
      sat_mag = (mag > 34'(Z_MAX)) ? 25'(Z_MAX) : mag[24:0];
      return $signed(sat_mag);
   endfunction

endpackage

### rtl/dpu_csr.sv
module dpu_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data,
   output dpu_pkg::cfg_type    cfg
);
   import dpu_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEPTH_SLOPE:   cfg_in.depth_slope   = csr_data[23:0];
            CSR_DEPTH_OFFSET:  cfg_in.depth_offset  = csr_data;
            CSR_INVERSE_FOCAL: cfg_in.inverse_focal = csr_data[23:0];
            CSR_CENTER_COLUMN: cfg_in.center_column = csr_data[9:0];
            CSR_CENTER_ROW:    cfg_in.center_row    = csr_data[9:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_slope   <= SLOPE_RESET;
         cfg_ff.depth_offset  <= OFFSET_RESET;
         cfg_ff.inverse_focal <= FOCAL_RESET;
         cfg_ff.center_column <= CCOL_RESET;
         cfg_ff.center_row    <= CROW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/dpu_ctrl.sv
module dpu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  dpu_pkg::stat_type   stat,
   output dpu_pkg::cmd_type    cmd
);
   import dpu_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DEN_MUL;
            end
         end
         ST_DEN_MUL: begin
            cmd.den_mul = 1'b1;
            state_in    = ST_DEN_SUB;
         end
         ST_DEN_SUB: begin
            cmd.den_sub = 1'b1;
            state_in    = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.prod_mul = 1'b1;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // an accepted item starts the sequence
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DEN_MUL))
      else $error("accepted item did not start processing");

   // a loaded result is offered on the next cycle
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |=> rsp_valid_ff)
      else $error("loaded result not offered");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // the sequencer moves on to the products when the divider finishes its last step
   a_div_last: assert property (@(posedge clock) disable iff (reset)
      (stat.div_last && state_ff == ST_DIV) |=> (state_ff == ST_PROD))
      else $error("divider end missed");

endmodule

### rtl/dpu_datapath.sv
module dpu_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  dpu_pkg::cfg_type          cfg,
   input  dpu_pkg::cmd_type          cmd,
   output dpu_pkg::stat_type         stat,
   input  logic [10:0]               req_raw_depth,
   input  logic                      req_frame_start,
   output logic signed [24:0]        rsp_point_x,
   output logic signed [24:0]        rsp_point_y,
   output logic [23:0]               rsp_point_z,
   output logic                      rsp_point_valid,
   output logic                      rsp_frame_last
);
   import dpu_pkg::*;

   // pixel position counters
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] col_cur;
   logic [ROW_BITS-1:0] row_cur;
   logic                col_end, row_end;

   // per item payload
   logic [10:0]  depth_ff;
   logic         last_ff;
   logic [9:0]   mag_x_ff, mag_y_ff;
   logic         neg_x_ff, neg_y_ff;
   logic [34:0]  sub_ff;
   logic [33:0]  ax_ff, ay_ff;
   logic [31:0]  den_ff;
   logic         pos_ff;
   logic         sat_ff;
   logic [31:0]  rem_ff;
   logic [QUOT_BITS-1:0] nbits_ff;
   logic [QUOT_BITS-1:0] quot_ff;
   logic [DIV_CNT_BITS-1:0] iter_ff;
   logic [23:0]  z_ff;
   logic [45:0]  x_lo_ff, x_hi_ff, y_lo_ff, y_hi_ff;

   // result register
   logic signed [24:0] out_x_ff, out_y_ff;
   logic [23:0]        out_z_ff;
   logic               out_valid_ff, out_last_ff;

   // combinational helpers
   logic [9:0]   row_ext;
   logic [46:0]  num;
   logic [32:0]  r1, r2;
   logic         ge1, ge2;
   logic [31:0]  r1_rem, r2_rem;
   logic [23:0]  z_sel;

   // position of this pixel and counter advance
   always_comb begin
      col_cur = req_frame_start ? '0 : col_ff;
      row_cur = req_frame_start ? '0 : row_ff;
      col_end = (col_cur >= COL_LAST);
      row_end = (row_cur >= ROW_LAST);
      col_in  = col_end ? '0 : col_cur + 1'b1;
      row_in  = col_end ? (row_end ? '0 : row_cur + 1'b1) : row_cur;
      row_ext = 10'(row_cur);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.load) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // capture the item and its signed pixel offsets
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         depth_ff <= req_raw_depth;
         last_ff  <= col_end && row_end;
         neg_x_ff <= col_cur < cfg.center_column;
         mag_x_ff <= (col_cur < cfg.center_column) ? cfg.center_column - col_cur
                                                   : col_cur - cfg.center_column;
         neg_y_ff <= row_ext < cfg.center_row;
         mag_y_ff <= (row_ext < cfg.center_row) ? cfg.center_row - row_ext
                                                : row_ext - cfg.center_row;
      end
   end

   // denominator product and offset scaling by inverse focal
   always_ff @(posedge clock) begin
      if (cmd.den_mul) begin
         sub_ff <= 35'(cfg.depth_slope) * 35'(depth_ff);
         ax_ff  <= 34'(mag_x_ff) * 34'(cfg.inverse_focal);
         ay_ff  <= 34'(mag_y_ff) * 34'(cfg.inverse_focal);
      end
   end

   // denominator and its sign
   always_ff @(posedge clock) begin
      if (cmd.den_sub) begin
         pos_ff <= sub_ff < 35'(cfg.depth_offset);
         den_ff <= cfg.depth_offset - sub_ff[31:0];
      end
   end

   // divider: rounded 2^46 / den, two quotient bits per step
   assign num = (47'd1 << 46) + 47'(den_ff >> 1);

   always_comb begin
      r1     = {rem_ff, nbits_ff[QUOT_BITS-1]};
      ge1    = r1 >= {1'b0, den_ff};
      r1_rem = ge1 ? 32'(r1 - {1'b0, den_ff}) : r1[31:0];
      r2     = {r1_rem, nbits_ff[QUOT_BITS-2]};
      ge2    = r2 >= {1'b0, den_ff};
      r2_rem = ge2 ? 32'(r2 - {1'b0, den_ff}) : r2[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         sat_ff   <= {10'd0, num} >= {den_ff, 25'd0};
         rem_ff   <= 32'(num[46:QUOT_BITS]);
         nbits_ff <= num[QUOT_BITS-1:0];
         quot_ff  <= '0;
         iter_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff   <= r2_rem;
         nbits_ff <= {nbits_ff[QUOT_BITS-3:0], 2'b00};
         quot_ff  <= {quot_ff[QUOT_BITS-3:0], ge1, ge2};
         iter_ff  <= iter_ff + 1'b1;
      end
   end

   assign stat.div_last = (iter_ff == DIV_CNT_BITS'(DIV_STEPS - 1));

   // saturated z, zero when the denominator is not positive
   always_comb begin
      if (!pos_ff) begin
         z_sel = '0;
      end else if (sat_ff || (quot_ff[QUOT_BITS-1:24] != '0)) begin
         z_sel = Z_MAX;
      end else begin
         z_sel = quot_ff[23:0];
      end
   end

   // lateral partial products, z split in two halves
   always_ff @(posedge clock) begin
      if (cmd.prod_mul) begin
         z_ff    <= z_sel;
         x_lo_ff <= 46'(ax_ff) * 46'(z_sel[11:0]);
         x_hi_ff <= 46'(ax_ff) * 46'(z_sel[23:12]);
         y_lo_ff <= 46'(ay_ff) * 46'(z_sel[11:0]);
         y_hi_ff <= 46'(ay_ff) * 46'(z_sel[23:12]);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         out_x_ff     <= lateral_finish(x_lo_ff, x_hi_ff, neg_x_ff);
         out_y_ff     <= lateral_finish(y_lo_ff, y_hi_ff, neg_y_ff);
         out_z_ff     <= z_ff;
         out_valid_ff <= pos_ff;
         out_last_ff  <= last_ff;
      end
   end

   assign rsp_point_x     = out_x_ff;
   assign rsp_point_y     = out_y_ff;
   assign rsp_point_z     = out_z_ff;
   assign rsp_point_valid = out_valid_ff;
   assign rsp_frame_last  = out_last_ff;

endmodule

### rtl/depth_pixel_unprojection_core.sv
// an accepted item steps through denominator, divider, product and sum states,
//    the radix-4 divider for 1/den setting the pace (13 iterations of two
//    quotient bits on one shared subtractor pair); the next item is taken once
//    its result is loaded, while that result still waits in the output register
// reset (synchronous, active high) clears the sequencer, output valid and the
//    pixel counters and loads the configuration registers with their defaults
module depth_pixel_unprojection_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [10:0]         req_raw_depth,
   input  logic                req_frame_start,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [24:0]  rsp_point_x,
   output logic signed [24:0]  rsp_point_y,
   output logic [23:0]         rsp_point_z,
   output logic                rsp_point_valid,
   output logic                rsp_frame_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data
);
   import dpu_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   // configuration registers
   dpu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // sequencer
   dpu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // arithmetic
   dpu_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .stat            (stat),
      .req_raw_depth   (req_raw_depth),
      .req_frame_start (req_frame_start),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z),
      .rsp_point_valid (rsp_point_valid),
      .rsp_frame_last  (rsp_frame_last)
   );

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

   import dpu_pkg::*;

   // register indexes that select no register
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LO = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_HI = 3'd7;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORDER [5] = '{
      CSR_DEPTH_SLOPE, CSR_DEPTH_OFFSET, CSR_INVERSE_FOCAL, CSR_CENTER_COLUMN, CSR_CENTER_ROW
   };

   localparam int RANDOM_PHASES = 8;
   localparam int LONG_PHASE    = 3;
   localparam int LONG_RUN_LEN  = 700;

   typedef struct packed {
      logic signed [24:0] point_x;
      logic signed [24:0] point_y;
      logic [23:0]        point_z;
      logic               point_valid;
      logic               frame_last;
   } point_type;

   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [31:0]               data;
      logic [10:0]               depth;
      logic                      start;
      logic                      typed;
      point_type                 want;
   } stim_row_type;

   // directed items and register writes; typed rows carry their own expected point
   localparam int DIR_ROWS = 33;
   stim_row_type dir_table [DIR_ROWS] = '{
      // reset settings: near, far beyond the denominator, around its zero crossing
      '{ROW_PIXEL, '0, '0, 11'd0,    1'b1, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd2047, 1'b0, 1'b1, '0},
      '{ROW_PIXEL, '0, '0, 11'd1000, 1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd1084, 1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd1085, 1'b1, 1'b1, '0},
      // zero slope and zero offset: denominator zero
      '{ROW_CSR, CSR_DEPTH_SLOPE,  32'd0, '0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_DEPTH_OFFSET, 32'd0, '0, 1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd0,    1'b0, 1'b1, '0},
      '{ROW_PIXEL, '0, '0, 11'd2047, 1'b0, 1'b1, '0},
      // largest offset
      '{ROW_CSR, CSR_DEPTH_OFFSET, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd2047, 1'b0, 1'b0, '0},
      // largest slope, upper data bits dropped
      '{ROW_CSR, CSR_DEPTH_SLOPE, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd255,  1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd256,  1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd257,  1'b0, 1'b1, '0},
      // denominator exactly zero, then tiny and positive
      '{ROW_CSR, CSR_DEPTH_SLOPE,  32'hAB00_03E8, '0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_DEPTH_OFFSET, 32'd2000000,   '0, 1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd2000, 1'b0, 1'b1, '0},
      '{ROW_PIXEL, '0, '0, 11'd1999, 1'b0, 1'b0, '0},
      // largest focal with centre far right and low: negative saturation
      '{ROW_CSR, CSR_INVERSE_FOCAL, 32'h00FF_FFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_CENTER_COLUMN, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_CENTER_ROW,    32'h0000_03FF, '0, 1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd1999, 1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd1998, 1'b0, 1'b0, '0},
      // centre at the origin: positive saturation
      '{ROW_CSR, CSR_CENTER_COLUMN, 32'd0,         '0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_CENTER_ROW,    32'hFFFF_FC00, '0, 1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd1999, 1'b0, 1'b0, '0},
      // zero inverse focal
      '{ROW_CSR, CSR_INVERSE_FOCAL, 32'hFF00_0000, '0, 1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd1999, 1'b0, 1'b0, '0},
      // writes to unused indexes change nothing
      '{ROW_CSR, CSR_UNUSED_LO, 32'd0,         '0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_UNUSED_HI, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd1500, 1'b0, 1'b0, '0},
      '{ROW_PIXEL, '0, '0, 11'd0,    1'b1, 1'b0, '0}
   };

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic                      req_ready;
   logic [10:0]               req_raw_depth   = '0;
   logic                      req_frame_start = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready       = 1'b0;
   logic signed [24:0]        rsp_point_x;
   logic signed [24:0]        rsp_point_y;
   logic [23:0]               rsp_point_z;
   logic                      rsp_point_valid;
   logic                      rsp_frame_last;
   logic                      csr_valid       = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index       = '0;
   logic [31:0]               csr_data        = '0;

   // predictor state: register copy and pixel position
   cfg_type           model_cfg = '{SLOPE_RESET, OFFSET_RESET, FOCAL_RESET, CCOL_RESET, CROW_RESET};
   logic [COL_BITS-1:0] pix_col = '0;
   logic [ROW_BITS-1:0] pix_row = '0;

   point_type expected_points [$];
   int        fail_count = 0;
   int        burst_left = 0;
   int        stall_left = 0;
   int        ready_pct  = 100;

   depth_pixel_unprojection_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_raw_depth   (req_raw_depth),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z),
      .rsp_point_valid (rsp_point_valid),
      .rsp_frame_last  (rsp_frame_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // pixel offset from the centre, scaled by z and inverse focal, to signed Q8.16
   function automatic logic [24:0] scale_offset(input logic [9:0] pos, input logic [9:0] centre,
                                                input logic [63:0] zq);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] prod;
      logic [63:0] mag_round;
      neg  = pos < centre;
      mag  = neg ? 64'(centre - pos) : 64'(pos - centre);
      prod = mag * zq * 64'(model_cfg.inverse_focal);
      mag_round = (prod + (64'd1 << 23)) >> 24;
      if (neg) begin
         if (mag_round > 64'h100_0000) mag_round = 64'h100_0000;
         return 25'(64'd0 - mag_round);
      end
      if (mag_round > 64'(Z_MAX)) mag_round = 64'(Z_MAX);
      return mag_round[24:0];
   endfunction

   // expected point for one pixel; advances the pixel position
   function automatic point_type predict_point(input logic [10:0] depth, input logic start);
      point_type   pt;
      logic        col_end;
      logic        row_end;
      logic [63:0] sub;
      logic [63:0] den;
      logic [63:0] zq;
      if (start) begin
         pix_col = '0;
         pix_row = '0;
      end
      col_end = pix_col >= COL_LAST;
      row_end = pix_row >= ROW_LAST;
      pt  = '0;
      sub = 64'(model_cfg.depth_slope) * 64'(depth);
      if (sub < 64'(model_cfg.depth_offset)) begin
         den = 64'(model_cfg.depth_offset) - sub;
         zq  = ((64'd1 << 46) + (den >> 1)) / den;
         if (zq > 64'(Z_MAX)) zq = 64'(Z_MAX);
         pt.point_x     = scale_offset(10'(pix_col), model_cfg.center_column, zq);
         pt.point_y     = scale_offset(10'(pix_row), model_cfg.center_row, zq);
         pt.point_z     = zq[23:0];
         pt.point_valid = 1'b1;
      end
      pt.frame_last = col_end && row_end;
      if (col_end) begin
         pix_col = '0;
         pix_row = row_end ? '0 : pix_row + 1'b1;
      end else begin
         pix_col = pix_col + 1'b1;
      end
      return pt;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_BITS-1:0] index,
                                     input logic [31:0] data);
      case (index)
         CSR_DEPTH_SLOPE:   model_cfg.depth_slope   = data[23:0];
         CSR_DEPTH_OFFSET:  model_cfg.depth_offset  = data;
         CSR_INVERSE_FOCAL: model_cfg.inverse_focal = data[23:0];
         CSR_CENTER_COLUMN: model_cfg.center_column = data[9:0];
         CSR_CENTER_ROW:    model_cfg.center_row    = data[9:0];
         default: ;
      endcase
   endfunction

   // random register value, realistic, extreme or arbitrary; junk in unused bits
   function automatic logic [31:0] pick_csr_value(input logic [CSR_INDEX_BITS-1:0] index,
                                                  input bit long_run);
      int          mode;
      logic [31:0] v;
      mode = $urandom_range(0, 5);
      case (index)
         CSR_DEPTH_SLOPE: begin
            if (long_run || mode == 2 || mode == 3) v = $urandom_range(2800000, 3400000);
            else if (mode == 0) v = 32'd0;
            else if (mode == 1) v = 32'h00FF_FFFF;
            else v = $urandom & 32'h00FF_FFFF;
            v = v | ($urandom & 32'hFF00_0000);
         end
         CSR_DEPTH_OFFSET: begin
            if (long_run || mode == 2 || mode == 3) v = $urandom_range(32'd3500000000, 32'd4000000000);
            else if (mode == 0) v = 32'd0;
            else if (mode == 1) v = 32'hFFFF_FFFF;
            else v = $urandom;
         end
         CSR_INVERSE_FOCAL: begin
            if (long_run || mode == 2 || mode == 3) v = $urandom_range(20000, 60000);
            else if (mode == 0) v = (($urandom_range(0, 1) == 0) ? 32'd0 : 32'd1);
            else if (mode == 1) v = 32'h00FF_FFFF;
            else v = $urandom & 32'h00FF_FFFF;
            v = v | ($urandom & 32'hFF00_0000);
         end
         CSR_CENTER_ROW: begin
            if (long_run) v = $urandom_range(0, 1);
            else if (mode == 0) v = 32'd0;
            else if (mode == 1) v = 32'd1023;
            else v = $urandom_range(0, 1023);
            v = v | ($urandom & 32'hFFFF_FC00);
         end
         default: begin
            if (mode == 0) v = 32'd0;
            else if (mode == 1) v = 32'd1023;
            else v = $urandom_range(0, 1023);
            v = v | ($urandom & 32'hFFFF_FC00);
         end
      endcase
      return v;
   endfunction

   // one pixel item, in bursts with random gaps between them
   task automatic send_pixel(input logic [10:0] depth, input logic start, input point_type want);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_raw_depth   <= depth;
      req_frame_start <= start;
      do @(posedge clock); while (!req_ready);
      expected_points = {expected_points, want};
   endtask

   // register write once every pending point has come out
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index, input logic [31:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // result receiver: ready is random, its probability redrawn whenever the stall counter runs out
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(50, 300);
         case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 35;
            default: ready_pct = 8;
         endcase
      end
      stall_left--;
      rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
   end

   // compare each accepted point with the oldest pending one
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected point, got x %h y %h z %h", $time,
                     rsp_point_x, rsp_point_y, rsp_point_z);
            fail_count++;
         end else begin
            want = expected_points.pop_front();
            check_field("point_x",     32'(want.point_x),     32'(rsp_point_x));
            check_field("point_y",     32'(want.point_y),     32'(rsp_point_y));
            check_field("point_z",     32'(want.point_z),     32'(rsp_point_z));
            check_field("point_valid", 32'(want.point_valid), 32'(rsp_point_valid));
            check_field("frame_last",  32'(want.frame_last),  32'(rsp_frame_last));
         end
      end
   end

   initial begin
      point_type   want;
      logic [10:0] depth;
      logic        start;
      int          run_len;
      bit          long_run;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_table[i].kind == ROW_CSR) begin
            write_csr(dir_table[i].index, dir_table[i].data);
         end else begin
            want = predict_point(dir_table[i].depth, dir_table[i].start);
            if (dir_table[i].typed) want = dir_table[i].want;
            send_pixel(dir_table[i].depth, dir_table[i].start, want);
         end
      end

      // random phases, one long enough to wrap the column counter
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         long_run = (phase == LONG_PHASE);
         foreach (CSR_ORDER[k]) write_csr(CSR_ORDER[k], pick_csr_value(CSR_ORDER[k], long_run));
         if ($urandom_range(0, 2) == 0)
            write_csr(3'($urandom_range(CSR_UNUSED_LO, CSR_UNUSED_HI)), $urandom);
         run_len = long_run ? LONG_RUN_LEN : $urandom_range(15, 40);
         for (int i = 0; i < run_len; i++) begin
            case ($urandom_range(0, 7))
               0: depth = 11'd0;
               1: depth = 11'd2047;
               default: depth = 11'($urandom_range(0, 2047));
            endcase
            // a frame mostly opens with its mark; stray marks only in short runs
            if (i == 0) start = ($urandom_range(0, 3) != 0);
            else start = !long_run && ($urandom_range(0, 49) == 0);
            want = predict_point(depth, start);
            send_pixel(depth, start, want);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/dpu_pkg.sv
rtl/dpu_csr.sv
rtl/dpu_ctrl.sv
rtl/dpu_datapath.sv
rtl/depth_pixel_unprojection_core.sv
verif/testbench.sv
